// ===== rtl/ael_pkg.sv =====
// ----------------------------------------------------------------------------
// ael_pkg
// Shared widths, codes and result types of the arithmetic expression lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package ael_pkg;

    localparam int CHAR_BITS           = 21;
    localparam int POS_BITS            = 16;
    localparam int COLUMN_BITS_DEFAULT = 16;
    localparam int MAX_DEPTH_DEFAULT   = 255;

    typedef enum logic [2:0] {
        TC_OPERATOR = 3'd0,
        TC_OPEN     = 3'd1,
        TC_CLOSE    = 3'd2,
        TC_NUMBER   = 3'd3,
        TC_ERROR    = 3'd4
    } token_class_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_UNEXPECTED = 3'd1,
        ERR_EXTRA      = 3'd2,
        ERR_POINT      = 3'd3,
        ERR_UNCLOSED   = 3'd4
    } error_code_t;

    typedef struct packed {
        token_class_t         token_class;
        logic [CHAR_BITS-1:0] char_out;
        logic                 token_start;
        logic [POS_BITS-1:0]  position;
        error_code_t          error_code;
        logic                 last_of_run;
    } result_t;

    // results written into the queue in one cycle
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

    typedef struct packed {
        logic       room;
        logic [2:0] count;
    } queue_status_t;

endpackage : ael_pkg

`default_nettype wire

// ===== rtl/ael_lexer.sv =====
// ----------------------------------------------------------------------------
// ael_lexer
// Input register, lexer state and the per-character classification step.
// ----------------------------------------------------------------------------
`default_nettype none

module ael_lexer
    import ael_pkg::*;
#(
    parameter int COLUMN_BITS = COLUMN_BITS_DEFAULT,
    parameter int MAX_DEPTH   = MAX_DEPTH_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [CHAR_BITS-1:0] char_code,
    input  wire logic                 end_of_text,
    input  wire queue_status_t        queue_status,
    output push_t                     push,
    output result_t                   res0,
    output result_t                   res1
);

    localparam int DEPTH_BITS = $clog2(MAX_DEPTH + 1);

    localparam logic [CHAR_BITS-1:0] CH_TAB    = CHAR_BITS'(32'h09);
    localparam logic [CHAR_BITS-1:0] CH_CR     = CHAR_BITS'(32'h0D);
    localparam logic [CHAR_BITS-1:0] CH_SPACE  = CHAR_BITS'(32'h20);
    localparam logic [CHAR_BITS-1:0] CH_ZERO   = CHAR_BITS'(32'h30);
    localparam logic [CHAR_BITS-1:0] CH_NINE   = CHAR_BITS'(32'h39);
    localparam logic [CHAR_BITS-1:0] CH_POINT  = CHAR_BITS'(32'h2E);
    localparam logic [CHAR_BITS-1:0] CH_COMMA  = CHAR_BITS'(32'h2C);
    localparam logic [CHAR_BITS-1:0] CH_OPEN   = CHAR_BITS'(32'h28);
    localparam logic [CHAR_BITS-1:0] CH_CLOSE  = CHAR_BITS'(32'h29);
    localparam logic [CHAR_BITS-1:0] CH_PLUS   = CHAR_BITS'(32'h2B);
    localparam logic [CHAR_BITS-1:0] CH_MINUS  = CHAR_BITS'(32'h2D);
    localparam logic [CHAR_BITS-1:0] CH_STAR   = CHAR_BITS'(32'h2A);
    localparam logic [CHAR_BITS-1:0] CH_SLASH  = CHAR_BITS'(32'h2F);
    localparam logic [CHAR_BITS-1:0] CH_CARET  = CHAR_BITS'(32'h5E);
    localparam logic [CHAR_BITS-1:0] CH_PCT    = CHAR_BITS'(32'h25);
    localparam logic [CHAR_BITS-1:0] CH_BSLASH = CHAR_BITS'(32'h5C);

    localparam logic [COLUMN_BITS-1:0] COL_MAX   = '1;
    localparam logic [DEPTH_BITS-1:0]  DEPTH_MAX = DEPTH_BITS'(MAX_DEPTH);

    function automatic logic is_blank(input logic [CHAR_BITS-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_operator(input logic [CHAR_BITS-1:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
               c == CH_CARET || c == CH_PCT || c == CH_BSLASH;
    endfunction

    // input register
    logic                 valid_reg;
    logic                 valid_next;
    logic [CHAR_BITS-1:0] char_reg;
    logic                 last_reg;
    logic                 accept;
    logic                 advance;

    // lexer state
    logic [COLUMN_BITS-1:0] column_reg,     column_next;
    logic [DEPTH_BITS-1:0]  depth_reg,      depth_next;
    logic                   in_number_reg,  in_number_next;
    logic                   point_reg,      point_next;
    logic [COLUMN_BITS-1:0] num_start_reg,  num_start_next;
    logic                   failed_reg,     failed_next;

    // step results
    logic                   tok_valid;
    result_t                tok;
    logic                   unclosed;
    result_t                unclosed_res;
    logic [COLUMN_BITS-1:0] col;
    logic [POS_BITS-1:0]    col_pos;
    logic [POS_BITS-1:0]    start_pos;
    logic                   continued;

    assign advance  = valid_reg && queue_status.room;
    assign in_stall = valid_reg && !queue_status.room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= char_code;
            last_reg <= end_of_text;
        end
    end

    assign col       = (column_reg < COL_MAX) ? column_reg + 1'b1 : column_reg;
    assign col_pos   = POS_BITS'(col);
    assign start_pos = POS_BITS'(num_start_reg);

    always_comb
    begin
        column_next    = col;
        depth_next     = depth_reg;
        in_number_next = in_number_reg;
        point_next     = point_reg;
        num_start_next = num_start_reg;
        failed_next    = failed_reg;
        continued      = 1'b0;
        tok_valid      = 1'b0;
        tok            = '{token_class: TC_ERROR, char_out: char_reg, token_start: 1'b0,
                           position: col_pos, error_code: ERR_NONE, last_of_run: 1'b0};

        if (!failed_reg)
        begin
            if (in_number_reg)
            begin
                if (is_digit(char_reg))
                begin
                    tok_valid       = 1'b1;
                    tok.token_class = TC_NUMBER;
                    tok.position    = start_pos;
                    continued       = 1'b1;
                end
                else if (char_reg == CH_POINT)
                begin
                    tok_valid = 1'b1;
                    continued = 1'b1;
                    if (point_reg)
                    begin
                        tok.error_code = ERR_POINT;
                        failed_next    = 1'b1;
                    end
                    else
                    begin
                        point_next      = 1'b1;
                        tok.token_class = TC_NUMBER;
                        tok.char_out    = CH_COMMA;
                        tok.position    = start_pos;
                    end
                end
                else
                begin
                    in_number_next = 1'b0;
                    point_next     = 1'b0;
                end
            end

            if (!continued && !is_blank(char_reg))
            begin
                tok_valid = 1'b1;
                priority if (is_operator(char_reg))
                begin
                    tok.token_class = TC_OPERATOR;
                    tok.token_start = 1'b1;
                end
                else if (char_reg == CH_OPEN)
                begin
                    if (depth_reg < DEPTH_MAX)
                    begin
                        depth_next = depth_reg + 1'b1;
                    end
                    tok.token_class = TC_OPEN;
                    tok.token_start = 1'b1;
                end
                else if (char_reg == CH_CLOSE)
                begin
                    if (depth_reg == '0)
                    begin
                        tok.error_code = ERR_EXTRA;
                        failed_next    = 1'b1;
                    end
                    else
                    begin
                        depth_next      = depth_reg - 1'b1;
                        tok.token_class = TC_CLOSE;
                        tok.token_start = 1'b1;
                    end
                end
                else if (is_digit(char_reg))
                begin
                    in_number_next  = 1'b1;
                    point_next      = 1'b0;
                    num_start_next  = col;
                    tok.token_class = TC_NUMBER;
                    tok.token_start = 1'b1;
                end
                else
                begin
                    tok.error_code = ERR_UNEXPECTED;
                    failed_next    = 1'b1;
                end
            end
        end

        // end of text clears everything
        if (last_reg)
        begin
            column_next    = '0;
            depth_next     = '0;
            in_number_next = 1'b0;
            point_next     = 1'b0;
            num_start_next = '0;
            failed_next    = 1'b0;
        end
    end

    // unclosed check looks at the state after this character, before clearing
    always_comb
    begin
        unclosed = last_reg && !failed_reg && (tok.error_code == ERR_NONE || !tok_valid);
        if (tok_valid && tok.token_class == TC_OPEN)
        begin
            unclosed = unclosed && 1'b1;
        end
        else if (tok_valid && tok.token_class == TC_CLOSE)
        begin
            unclosed = unclosed && (depth_reg > DEPTH_BITS'(1));
        end
        else
        begin
            unclosed = unclosed && (depth_reg != '0);
        end
        unclosed_res = '{token_class: TC_ERROR, char_out: '0, token_start: 1'b0,
                         position: col_pos, error_code: ERR_UNCLOSED, last_of_run: 1'b1};
    end

    always_comb
    begin
        push = '{first: 1'b0, second: 1'b0};
        res0 = unclosed_res;
        res1 = unclosed_res;
        if (advance)
        begin
            if (tok_valid)
            begin
                push.first       = 1'b1;
                push.second      = unclosed;
                res0             = tok;
                res0.last_of_run = !unclosed;
            end
            else
            begin
                push.first = unclosed;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            depth_reg     <= '0;
            in_number_reg <= 1'b0;
            point_reg     <= 1'b0;
            num_start_reg <= '0;
            failed_reg    <= 1'b0;
        end
        else if (advance)
        begin
            column_reg    <= column_next;
            depth_reg     <= depth_next;
            in_number_reg <= in_number_next;
            point_reg     <= point_next;
            num_start_reg <= num_start_next;
            failed_reg    <= failed_next;
        end
    end

endmodule : ael_lexer

`default_nettype wire

// ===== rtl/ael_result_queue.sv =====
// ----------------------------------------------------------------------------
// ael_result_queue
// Four-entry result queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ael_result_queue
    import ael_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire push_t   push,
    input  wire result_t res0,
    input  wire result_t res1,
    output queue_status_t status,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      head
);

    localparam int DEPTH = 4;
    localparam int PTR_BITS = $clog2(DEPTH);

    result_t             entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0]          count_reg,  count_next;
    logic                pop;
    logic [1:0]          n_push;

    assign out_valid    = count_reg != '0;
    assign head         = entry_reg[rd_ptr_reg];
    assign pop          = out_valid && !out_stall;
    // room for two results, judged from registered count only
    assign status.room  = count_reg <= 3'(DEPTH - 2);
    assign status.count = count_reg;

    assign n_push = 2'(push.first) + 2'(push.second);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(n_push);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + 3'(n_push) - 3'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            entry_reg[wr_ptr_reg] <= res0;
        end
        if (push.second)
        begin
            entry_reg[wr_ptr_reg + 1'b1] <= res1;
        end
    end

endmodule : ael_result_queue

`default_nettype wire

// ===== rtl/arithmetic_expression_lexer_core.sv =====
// ----------------------------------------------------------------------------
// arithmetic_expression_lexer_core
// Streaming lexer for arithmetic expressions, one character per item.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with char_code and end_of_text; one
// character per item, end_of_text set on the final character.
// Output channel: out_valid / out_stall with one token character or error
// per item; last_of_run marks the final result of an input character.
// Blanks give no token; a character gives at most two results (its token
// and, on the final character, an unclosed-parenthesis error).
// Path: a taken character waits in the input register until the queue has
// room; its results are then written into the queue and offered from there.
// Throughput: one character per cycle while each gives at most one result;
// the output port moves one result per cycle, so the two results of a
// character leave one after the other. The four-entry result queue sets
// this: a character is processed only while two entries are free.
// Stall: out_stall holds results in the queue; once fewer than two entries
// are free, in_stall rises and the waiting character stays in the input
// register.
// Reset: clears column, depth, number and failure state and empties the
// queue; the same state clears after every character with end_of_text.
// ----------------------------------------------------------------------------
`default_nettype none

module arithmetic_expression_lexer_core
    import ael_pkg::*;
#(
    parameter int COLUMN_BITS = COLUMN_BITS_DEFAULT,
    parameter int MAX_DEPTH   = MAX_DEPTH_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [CHAR_BITS-1:0] char_code,
    input  wire logic                 end_of_text,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [2:0]                token_class,
    output logic [CHAR_BITS-1:0]      char_out,
    output logic                      token_start,
    output logic [POS_BITS-1:0]       position,
    output logic [2:0]                error_code,
    output logic                      last_of_run
);

    push_t         push;
    result_t       res0;
    result_t       res1;
    result_t       head;
    queue_status_t queue_status;

    ael_lexer #(
        .COLUMN_BITS (COLUMN_BITS),
        .MAX_DEPTH   (MAX_DEPTH)
    ) u_lexer (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .end_of_text  (end_of_text),
        .queue_status (queue_status),
        .push         (push),
        .res0         (res0),
        .res1         (res1)
    );

    ael_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .res0      (res0),
        .res1      (res1),
        .status    (queue_status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign token_class = head.token_class;
    assign char_out    = head.char_out;
    assign token_start = head.token_start;
    assign position    = head.position;
    assign error_code  = head.error_code;
    assign last_of_run = head.last_of_run;

    // the queue is never written without room for two results
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.first || push.second) |-> queue_status.room)
        else $error("result written while queue short of room");

    // a second result is always the closing unclosed error
    assert property (@(posedge clk) disable iff (!rst_n)
        push.second |-> (push.first && res1.error_code == ERR_UNCLOSED &&
                         res1.last_of_run && !res0.last_of_run))
        else $error("malformed result pair");

    // a lone result closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.first && !push.second) |-> res0.last_of_run)
        else $error("single result without last_of_run");

    // queue occupancy stays within its four entries
    assert property (@(posedge clk) disable iff (!rst_n)
        queue_status.count <= 3'd4)
        else $error("result queue overflow");

endmodule : arithmetic_expression_lexer_core

`default_nettype wire
